@@ hw/rtl/ilir_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilir_pkg: shared types and constants for the indexed list
// Transaction structs, operation codes and cell control word.
// ----------------------------------------------------------------------------
package ilir_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int LEN_W    = 5;
	localparam int POS_W    = 5;
	localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	typedef enum logic [2:0] {
		OP_ADD_HEAD = 3'd0,
		OP_ADD_TAIL = 3'd1,
		OP_REM_HEAD = 3'd2,
		OP_REM_TAIL = 3'd3,
		OP_INSERT   = 3'd4,
		OP_REM_AT   = 3'd5,
		OP_CLEAR    = 3'd6
	} op_t;

	typedef struct packed {
		logic [2:0]         func;
		logic signed [31:0] value_in;
		logic [POS_W-1:0]   position;
	} req_t;

	typedef struct packed {
		logic               ok;
		logic signed [31:0] value_out;
		logic [LEN_W-1:0]   length;
	} rsp_t;

	typedef struct packed {
		logic             ins;
		logic             rem;
		logic             clr;
		logic             ok;
		logic [IDX_W-1:0] idx;
	} ctl_t;

	function automatic logic [LEN_W-1:0] to_len(input logic [CNT_W-1:0] c);
		logic [CNT_W+LEN_W-1:0] w;
		w = (CNT_W + LEN_W)'(c);
		return w[LEN_W-1:0];
	endfunction

endpackage

@@ hw/rtl/ilir_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilir_ctrl: operation decode
// Checks a command against the fill level and issues the cell control word.
// ----------------------------------------------------------------------------
module ilir_ctrl
	import ilir_pkg::*;
(
	input  logic             accept,
	input  req_t             cmd,
	input  logic [CNT_W-1:0] count_q,
	output ctl_t             ctl
);

	logic             full;
	logic             empty;
	logic [CMP_W-1:0] pos_x;
	logic [CMP_W-1:0] cnt_x;
	logic [CNT_W-1:0] last;

	assign full  = (count_q >= CNT_W'(CAPACITY));
	assign empty = (count_q == '0);
	assign pos_x = CMP_W'(cmd.position);
	assign cnt_x = CMP_W'(count_q);
	assign last  = count_q - CNT_W'(1);

	always_comb begin
		ctl = '0;
		case (op_t'(cmd.func))
			OP_ADD_HEAD: begin
				ctl.ins = !full;
			end
			OP_ADD_TAIL: begin
				ctl.ins = !full;
				ctl.idx = count_q[IDX_W-1:0];
			end
			OP_REM_HEAD: begin
				ctl.rem = !empty;
			end
			OP_REM_TAIL: begin
				ctl.rem = !empty;
				ctl.idx = last[IDX_W-1:0];
			end
			OP_INSERT: begin
				ctl.ins = !empty && !full && (pos_x <= cnt_x);
				ctl.idx = cmd.position[IDX_W-1:0];
			end
			OP_REM_AT: begin
				ctl.rem = (pos_x < cnt_x);
				ctl.idx = cmd.position[IDX_W-1:0];
			end
			OP_CLEAR: begin
				ctl.clr = 1'b1;
			end
			default: begin
				ctl = '0;
			end
		endcase
		ctl.ok  = ctl.ins || ctl.rem || ctl.clr;
		ctl.ins = ctl.ins && accept;
		ctl.rem = ctl.rem && accept;
		ctl.clr = ctl.clr && accept;
	end

endmodule

@@ hw/rtl/ilir_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilir_cell: one list slot
// Holds one entry; shifts from its left neighbor on insert, from its right
// neighbor on remove, or loads the new value when it is the insert slot.
// ----------------------------------------------------------------------------
module ilir_cell
	import ilir_pkg::*;
(
	input  logic               clk,
	input  ctl_t               ctl,
	input  logic [IDX_W-1:0]   cell_idx,
	input  logic signed [31:0] value_in,
	input  logic signed [31:0] left_val,
	input  logic signed [31:0] right_val,
	output logic signed [31:0] data_q
);

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (cell_idx > ctl.idx) begin
				data_q <= left_val;
			end else if (cell_idx == ctl.idx) begin
				data_q <= value_in;
			end
		end else if (ctl.rem) begin
			if (cell_idx >= ctl.idx) begin
				data_q <= right_val;
			end
		end
	end

endmodule

@@ hw/rtl/indexed_list_insert_remove.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_insert_remove: ordered list of signed 32-bit values
// Takes one command per cycle (busy stays low); each accepted transaction
// returns its result on rsp with done high for exactly one cycle, on the
// cycle after start. A row of CAPACITY cells shifts every entry in the same
// cycle on insert or remove, so each operation finishes in that one cycle.
// The result is not held: the receiver must take it when done is high.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove
	import ilir_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t cmd,
	output logic done,
	output rsp_t rsp
);

	logic               accept;
	ctl_t               ctl;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_nx;
	logic signed [31:0] cell_data [CAPACITY];
	logic signed [31:0] removed;
	logic               done_q;
	rsp_t               rsp_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	ilir_ctrl u_ctrl (
		.accept  (accept),
		.cmd     (cmd),
		.count_q (count_q),
		.ctl     (ctl)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [31:0] left_v;
		logic signed [31:0] right_v;

		if (i == 0) begin : g_first
			assign left_v = '0;
		end else begin : g_mid_l
			assign left_v = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_v = '0;
		end else begin : g_mid_r
			assign right_v = cell_data[i+1];
		end

		ilir_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.cell_idx  (IDX_W'(i)),
			.value_in  (cmd.value_in),
			.left_val  (left_v),
			.right_val (right_v),
			.data_q    (cell_data[i])
		);
	end

	assign removed = cell_data[ctl.idx];

	always_comb begin
		count_nx = count_q;
		if (ctl.clr) begin
			count_nx = '0;
		end else if (ctl.ins) begin
			count_nx = count_q + CNT_W'(1);
		end else if (ctl.rem) begin
			count_nx = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_nx;
			done_q  <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.ok        <= ctl.ok;
			rsp_q.value_out <= ctl.rem ? removed : 32'sd0;
			rsp_q.length    <= to_len(count_nx);
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

@@ hw/rtl/ilir_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilir_checker: port-level checks for the indexed list
// Result timing and result field consistency, bound to the top level.
// ----------------------------------------------------------------------------
module ilir_checker
	import ilir_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input req_t cmd,
	input logic done,
	input rsp_t rsp
);

	a_resp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("accepted transaction gave no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy))
		else $error("result without a transaction");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.ok) |-> (rsp.value_out == 32'sd0))
		else $error("rejected transaction returned a value");

	a_clear_len: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(cmd.func) == OP_CLEAR) |-> (rsp.ok && rsp.length == '0))
		else $error("clear did not empty the list");

endmodule

bind indexed_list_insert_remove ilir_checker u_ilir_checker (.*);

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for indexed_list_insert_remove
// Drives list operations through the start/busy command port, predicts each
// result from a shadow copy of the list and checks every done strobe, field
// by field, in order. Directed corner cases come first, then random
// fill-heavy and drain-heavy phases that reach both the full and the empty
// list.
// ----------------------------------------------------------------------------
module testbench;
	import ilir_pkg::*;

	localparam logic [2:0] FUNC_UNUSED = 3'd7;
	localparam int         RAND_ITEMS  = 750;
	localparam int         MAX_REPORTS = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t cmd = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	req_t pending_ops[$];
	rsp_t expected_rsp[$];

	logic signed [31:0] shadow_vals[CAPACITY];
	int shadow_len = 0;

	int issued = 0;
	int accepted = 0;
	int checked = 0;
	int mismatches = 0;
	int ok_count = 0;
	int full_rejects = 0;
	int empty_rejects = 0;

	indexed_list_insert_remove DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.rsp    (rsp)
	);

	always #6 clk = ~clk;

	task automatic shadow_put(input int idx, input logic signed [31:0] v);
		for (int i = shadow_len; i > idx; i--)
			shadow_vals[i] = shadow_vals[i - 1];
		shadow_vals[idx] = v;
		shadow_len++;
	endtask

	task automatic shadow_take(input int idx, output logic signed [31:0] v);
		v = shadow_vals[idx];
		for (int i = idx; i + 1 < shadow_len; i++)
			shadow_vals[i] = shadow_vals[i + 1];
		shadow_len--;
	endtask

	// apply one operation to the shadow list and return the expected response
	task automatic list_apply(input req_t c, output rsp_t r);
		logic full;
		logic signed [31:0] taken;
		r = '0;
		taken = '0;
		full = (shadow_len >= CAPACITY);
		case (c.func)
			OP_ADD_HEAD, OP_ADD_TAIL: begin
				if (!full) begin
					shadow_put((c.func == OP_ADD_HEAD) ? 0 : shadow_len, c.value_in);
					r.ok = 1'b1;
				end else begin
					full_rejects++;
				end
			end
			OP_REM_HEAD, OP_REM_TAIL: begin
				if (shadow_len > 0) begin
					shadow_take((c.func == OP_REM_HEAD) ? 0 : shadow_len - 1, taken);
					r.ok = 1'b1;
				end else begin
					empty_rejects++;
				end
			end
			OP_INSERT: begin
				if (shadow_len > 0 && !full && int'(c.position) <= shadow_len) begin
					shadow_put(int'(c.position), c.value_in);
					r.ok = 1'b1;
				end else if (full) begin
					full_rejects++;
				end else if (shadow_len == 0) begin
					empty_rejects++;
				end
			end
			OP_REM_AT: begin
				if (int'(c.position) < shadow_len) begin
					shadow_take(int'(c.position), taken);
					r.ok = 1'b1;
				end else if (shadow_len == 0) begin
					empty_rejects++;
				end
			end
			OP_CLEAR: begin
				shadow_len = 0;
				r.ok = 1'b1;
			end
			default: ;
		endcase
		r.value_out = taken;
		r.length = LEN_W'(shadow_len);
		if (r.ok)
			ok_count++;
	endtask

	function automatic req_t make_op(input logic [2:0] f, input logic signed [31:0] v,
			input int p);
		req_t c;
		c.func = f;
		c.value_in = v;
		c.position = POS_W'(p);
		return c;
	endfunction

	function automatic req_t rand_op(input bit filling);
		int r;
		logic [2:0] f;
		logic signed [31:0] v;
		int p;
		r = $urandom_range(99);
		if (filling) begin
			if (r < 25)      f = OP_ADD_HEAD;
			else if (r < 48) f = OP_ADD_TAIL;
			else if (r < 70) f = OP_INSERT;
			else if (r < 79) f = OP_REM_HEAD;
			else if (r < 88) f = OP_REM_TAIL;
			else if (r < 97) f = OP_REM_AT;
			else if (r < 98) f = OP_CLEAR;
			else             f = FUNC_UNUSED;
		end else begin
			if (r < 9)       f = OP_ADD_HEAD;
			else if (r < 17) f = OP_ADD_TAIL;
			else if (r < 25) f = OP_INSERT;
			else if (r < 48) f = OP_REM_HEAD;
			else if (r < 71) f = OP_REM_TAIL;
			else if (r < 95) f = OP_REM_AT;
			else if (r < 98) f = OP_CLEAR;
			else             f = FUNC_UNUSED;
		end
		case ($urandom_range(19))
			0:       v = 32'sh8000_0000;
			1:       v = 32'sh7fff_ffff;
			2:       v = '0;
			3:       v = -32'sd1;
			default: v = $urandom;
		endcase
		p = ($urandom_range(9) < 8) ? $urandom_range(0, 17) : $urandom_range(0, 31);
		return make_op(f, v, p);
	endfunction

	// driver: a held command stays put while busy, otherwise the next one goes out or start drops for a random gap
	always @(posedge clk or negedge arst_n) begin
		rsp_t r;
		bit quiet;
		if (!arst_n) begin
			start <= 1'b0;
			cmd <= '0;
		end else begin
			if (start && !busy) begin
				list_apply(cmd, r);
				expected_rsp.push_back(r);
				accepted++;
			end
			if (!start || !busy) begin
				quiet = (issued >= 300 && issued < 420);
				if (pending_ops.size() > 0 && (quiet || $urandom_range(99) >= 31)) begin
					cmd <= pending_ops.pop_front();
					start <= 1'b1;
					issued++;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done) begin
			if (expected_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected result ok=%0b value=%0d len=%0d",
						$realtime, rsp.ok, rsp.value_out, rsp.length);
			end else begin
				want = expected_rsp.pop_front();
				checked++;
				if (rsp.ok !== want.ok || rsp.value_out !== want.value_out ||
						rsp.length !== want.length) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: result %0d exp ok=%0b value=%0d len=%0d, got ok=%0b value=%0d len=%0d",
							$realtime, checked, want.ok, want.value_out, want.length,
							rsp.ok, rsp.value_out, rsp.length);
				end
			end
		end
	end

	initial begin
		bit filling;
		int phase_left;
		// directed corners: empty list, extremes, insert and remove bounds
		pending_ops.push_back(make_op(OP_CLEAR, 0, 0));
		pending_ops.push_back(make_op(OP_REM_HEAD, 0, 0));
		pending_ops.push_back(make_op(OP_REM_TAIL, 0, 0));
		pending_ops.push_back(make_op(OP_REM_AT, 0, 0));
		pending_ops.push_back(make_op(OP_INSERT, 5, 0));
		pending_ops.push_back(make_op(OP_ADD_TAIL, 32'sh8000_0000, 31));
		pending_ops.push_back(make_op(OP_ADD_HEAD, 32'sh7fff_ffff, 0));
		pending_ops.push_back(make_op(OP_INSERT, -1, 2));
		pending_ops.push_back(make_op(OP_INSERT, 0, 0));
		pending_ops.push_back(make_op(OP_INSERT, 7, 5));
		pending_ops.push_back(make_op(OP_INSERT, 7, 31));
		pending_ops.push_back(make_op(OP_REM_AT, 0, 4));
		pending_ops.push_back(make_op(OP_REM_AT, 0, 3));
		pending_ops.push_back(make_op(OP_ADD_TAIL, 32'sh5a5a_a5a5, 0));
		pending_ops.push_back(make_op(FUNC_UNUSED, -1, 31));
		pending_ops.push_back(make_op(OP_REM_AT, 0, 1));
		pending_ops.push_back(make_op(OP_REM_TAIL, 0, 0));
		pending_ops.push_back(make_op(OP_REM_HEAD, 0, 0));
		pending_ops.push_back(make_op(OP_REM_AT, 0, 31));
		pending_ops.push_back(make_op(OP_CLEAR, 0, 0));
		pending_ops.push_back(make_op(OP_REM_AT, 0, 0));
		// random: alternating fill-heavy and drain-heavy phases
		filling = 1'b1;
		phase_left = $urandom_range(25, 60);
		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (phase_left == 0) begin
				filling = !filling;
				phase_left = $urandom_range(20, 60);
			end
			phase_left--;
			pending_ops.push_back(rand_op(filling));
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_ops.size() > 0 || start || expected_rsp.size() > 0)
			@(posedge clk);
		repeat (5) @(posedge clk);

		$display("Ran %0d transactions, %0d results checked, %0d succeeded.",
			accepted, checked, ok_count);
		$display("Rejections seen: %0d on a full list, %0d on an empty list.",
			full_rejects, empty_rejects);
		if (mismatches == 0 && checked == accepted)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#2_400_000;
		$display("Timeout with %0d transactions still outstanding.",
			pending_ops.size() + expected_rsp.size());
		$display("FAILED: results differ");
		$finish;
	end

endmodule
